[src/spef_pkg.sv]
// Shared types and constants for the safety-protected event queue.
package spef_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_BITS_DEF   = 32;
    localparam int TYPE_W          = 8;
    localparam int TIME_W          = 32;
    localparam int DROP_W          = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 8;

    // Request codes carried on the command field.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SAFETY_FIRST = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAFETY_LAST  = 1'b1;

    // Update strobes and the safety range, broadcast to every queue cell.
    typedef struct packed {
        logic              shift;
        logic              append;
        logic              overwrite;
        logic [TYPE_W-1:0] safe_first;
        logic [TYPE_W-1:0] safe_last;
    } cell_ctrl_t;

endpackage

[src/spef_cell.sv]
// One queue cell: holds one event and takes part in the oldest-ordinary-entry search.
module spef_cell #(
    parameter int DATA_BITS = spef_pkg::DATA_BITS_DEF
) (
    input  logic                       clk,
    input  spef_pkg::cell_ctrl_t       ctrl,
    input  logic                       in_use,
    input  logic                       is_tail,
    input  logic                       found_in,
    output logic                       found_out,
    input  logic [spef_pkg::TYPE_W-1:0] new_type,
    input  logic [spef_pkg::TIME_W-1:0] new_time,
    input  logic [DATA_BITS-1:0]        new_data,
    input  logic [spef_pkg::TYPE_W-1:0] up_type,
    input  logic [spef_pkg::TIME_W-1:0] up_time,
    input  logic [DATA_BITS-1:0]        up_data,
    output logic [spef_pkg::TYPE_W-1:0] cell_type,
    output logic [spef_pkg::TIME_W-1:0] cell_time,
    output logic [DATA_BITS-1:0]        cell_data
);

    logic [spef_pkg::TYPE_W-1:0] type_reg, type_next;
    logic [spef_pkg::TIME_W-1:0] time_reg, time_next;
    logic [DATA_BITS-1:0]        data_reg, data_next;
    logic                        safe;
    logic                        ordinary;

    assign safe      = (type_reg >= ctrl.safe_first) && (type_reg <= ctrl.safe_last);
    assign ordinary  = in_use && !safe;
    // The search result ripples toward the newer end of the queue.
    assign found_out = found_in || ordinary;

    always_comb
    begin
        type_next = type_reg;
        time_next = time_reg;
        data_next = data_reg;
        priority if (ctrl.shift)
        begin
            type_next = up_type;
            time_next = up_time;
            data_next = up_data;
        end
        else if ((ctrl.append && is_tail) || (ctrl.overwrite && ordinary && !found_in))
        begin
            type_next = new_type;
            time_next = new_time;
            data_next = new_data;
        end
        else
        begin
            // The stored event stays as it is.
            type_next = type_reg;
            time_next = time_reg;
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        time_reg <= time_next;
        data_reg <= data_next;
    end

    assign cell_type = type_reg;
    assign cell_time = time_reg;
    assign cell_data = data_reg;

endmodule

[src/safety_protected_event_fifo.sv]
// Top level of the safety-protected event queue: handshake, control and the row of cells.
//
// The block takes one request at a time on the input channel (in_valid/in_ready).
// A push request carries an event type, a timestamp (zero means take now_ms) and
// a payload; a pop request returns the oldest stored event. Each request yields
// exactly one response on the output channel (out_valid/out_ready) with the status
// flags, the popped fields (zero unless a pop returned an entry), the fill level
// and the saturating count of dropped ordinary events.
// The request is captured at the edge that accepts it; in the following execute
// cycle the cells update and the search for the oldest ordinary entry ripples
// along the row of QUEUE_DEPTH cells. The response is registered in the output
// register when the execute cycle completes, and no new request is taken before
// that, since in_ready is low during the execute cycle.
// The output register parts the two sides, so a new request is accepted while a
// response still waits. If the receiver stalls, the captured request holds in the
// execute cycle until the output register is free; nothing is lost.
// Reset empties the queue, clears the drop counter and sets both safety range
// bounds to zero. No clearing pass is needed: stored entries are only ever read
// below the fill level. Configuration writes take effect on the next edge.
module safety_protected_event_fifo #(
    parameter int QUEUE_DEPTH = spef_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_BITS   = spef_pkg::DATA_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [spef_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spef_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic [spef_pkg::TYPE_W-1:0]        event_type,
    input  logic [spef_pkg::TIME_W-1:0]        event_time_ms,
    input  logic [DATA_BITS-1:0]               event_data,
    input  logic [spef_pkg::TIME_W-1:0]        now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               ok,
    output logic                               overwrote,
    output logic [spef_pkg::TYPE_W-1:0]        popped_type,
    output logic [spef_pkg::TIME_W-1:0]        popped_time_ms,
    output logic [DATA_BITS-1:0]               popped_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill_level,
    output logic [spef_pkg::DROP_W-1:0]        drops_seen
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [spef_pkg::TYPE_W-1:0] first_reg, first_next;
    logic [spef_pkg::TYPE_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [spef_pkg::DROP_W-1:0] drops_reg, drops_next;

    // Captured request; the timestamp is already resolved against now_ms.
    logic                        req_cmd_reg, req_cmd_next;
    logic [spef_pkg::TYPE_W-1:0] req_type_reg, req_type_next;
    logic [spef_pkg::TIME_W-1:0] req_time_reg, req_time_next;
    logic [DATA_BITS-1:0]        req_data_reg, req_data_next;

    // Response register.
    logic                        out_valid_reg, out_valid_next;
    logic                        out_ok_reg, out_ok_next;
    logic                        out_over_reg, out_over_next;
    logic [spef_pkg::TYPE_W-1:0] out_type_reg, out_type_next;
    logic [spef_pkg::TIME_W-1:0] out_time_reg, out_time_next;
    logic [DATA_BITS-1:0]        out_data_reg, out_data_next;

    spef_pkg::cell_ctrl_t        ctrl;
    logic [QUEUE_DEPTH:0]        found;
    logic [spef_pkg::TYPE_W-1:0] cell_type [QUEUE_DEPTH];
    logic [spef_pkg::TIME_W-1:0] cell_time [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]        cell_data [QUEUE_DEPTH];

    logic accept;
    logic go;
    logic is_push;
    logic full;
    logic empty;
    logic new_safe;
    logic hit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    // The execute cycle completes only when the response register can take its result.
    assign go       = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign is_push  = (req_cmd_reg == spef_pkg::CMD_PUSH);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign new_safe = (req_type_reg >= first_reg) && (req_type_reg <= last_reg);
    assign hit      = found[QUEUE_DEPTH];

    always_comb
    begin
        ctrl.shift      = go && !is_push && !empty;
        ctrl.append     = go && is_push && !full;
        ctrl.overwrite  = go && is_push && full && new_safe;
        ctrl.safe_first = first_reg;
        ctrl.safe_last  = last_reg;
    end

    // Cell 0 holds the oldest event; a pop shifts every cell one place toward it.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [spef_pkg::TYPE_W-1:0] up_type;
        logic [spef_pkg::TIME_W-1:0] up_time;
        logic [DATA_BITS-1:0]        up_data;

        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign up_type = req_type_reg;
            assign up_time = req_time_reg;
            assign up_data = req_data_reg;
        end
        else
        begin : g_mid
            assign up_type = cell_type[i+1];
            assign up_time = cell_time[i+1];
            assign up_data = cell_data[i+1];
        end

        spef_cell #(
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .in_use    (count_reg > CNT_W'(i)),
            .is_tail   (count_reg == CNT_W'(i)),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .new_type  (req_type_reg),
            .new_time  (req_time_reg),
            .new_data  (req_data_reg),
            .up_type   (up_type),
            .up_time   (up_time),
            .up_data   (up_data),
            .cell_type (cell_type[i]),
            .cell_time (cell_time[i]),
            .cell_data (cell_data[i])
        );
    end

    always_comb
    begin
        first_next = first_reg;
        last_next  = last_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                spef_pkg::CFG_SAFETY_FIRST: first_next = cfg_wdata;
                spef_pkg::CFG_SAFETY_LAST:  last_next  = cfg_wdata;
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        req_cmd_next  = req_cmd_reg;
        req_type_next = req_type_reg;
        req_time_next = req_time_reg;
        req_data_next = req_data_reg;
        if (accept)
        begin
            req_cmd_next  = command;
            req_type_next = event_type;
            req_time_next = (event_time_ms == '0) ? now_ms : event_time_ms;
            req_data_next = event_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Queue bookkeeping and the response for the request in the execute cycle.
    always_comb
    begin
        count_next     = count_reg;
        drops_next     = drops_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_over_next  = out_over_reg;
        out_type_next  = out_type_reg;
        out_time_next  = out_time_reg;
        out_data_next  = out_data_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (go)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = 1'b0;
            out_over_next  = 1'b0;
            out_type_next  = '0;
            out_time_next  = '0;
            out_data_next  = '0;
            if (is_push)
            begin
                priority if (!full)
                begin
                    count_next  = count_reg + CNT_W'(1);
                    out_ok_next = 1'b1;
                end
                else if (new_safe)
                begin
                    // Overwrites the oldest ordinary entry; if none, dropped uncounted.
                    out_ok_next   = hit;
                    out_over_next = hit;
                end
                else
                begin
                    // An ordinary event is dropped; the counter saturates.
                    if (drops_reg != '1)
                    begin
                        drops_next = drops_reg + spef_pkg::DROP_W'(1);
                    end
                end
            end
            else if (!empty)
            begin
                count_next    = count_reg - CNT_W'(1);
                out_ok_next   = 1'b1;
                out_type_next = cell_type[0];
                out_time_next = cell_time[0];
                out_data_next = cell_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            drops_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            drops_reg     <= drops_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_cmd_reg  <= req_cmd_next;
        req_type_reg <= req_type_next;
        req_time_reg <= req_time_next;
        req_data_reg <= req_data_next;
        out_ok_reg   <= out_ok_next;
        out_over_reg <= out_over_next;
        out_type_reg <= out_type_next;
        out_time_reg <= out_time_next;
        out_data_reg <= out_data_next;
    end

    // Fill level and drop count only change in an execute cycle, which waits
    // for the response register, so they hold steady while a response is shown.
    assign out_valid      = out_valid_reg;
    assign ok             = out_ok_reg;
    assign overwrote      = out_over_reg;
    assign popped_type    = out_type_reg;
    assign popped_time_ms = out_time_reg;
    assign popped_data    = out_data_reg;
    assign fill_level     = count_reg;
    assign drops_seen     = drops_reg;

endmodule
